// File: design/nmf_pkg.sv
// ----------------------------------------------------------------------------
// nmf_pkg
// shared constants and types of the neighbor median filter
// ----------------------------------------------------------------------------
package nmf_pkg;

  localparam int MAX_SIDE_DEF   = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  // frame size register
  localparam int                 CFG_W        = 11;
  localparam logic [CFG_W-1:0]   FRAME_RESET  = 11'd3;

  // job queue between front and back
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);

  // which results one input word causes, in emit order
  typedef struct packed {
    logic ab;    // previous row: left border, top-row pixel or window median
    logic rc;    // previous row: right border
    logic cur;   // last row: the word itself
    logic last;  // cur result closes the frame
  } emit_t;

  localparam int EMIT_W = $bits(emit_t);

endpackage

// File: design/nmf_front.sv
// ----------------------------------------------------------------------------
// nmf_front
// position counters, line stores, 3x3 window and neighbor sort pipeline
// ----------------------------------------------------------------------------
module nmf_front import nmf_pkg::*; #(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int CW = $clog2(MAX_SIDE),
  localparam int PB = PIXEL_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [PB-1:0]    pixel_in_i,
  input  logic [QAW:0]     q_count_i,
  output logic             push_o,
  output logic [PB-1:0]    val_ab_o,
  output logic [PB-1:0]    val_rc_o,
  output logic [PB-1:0]    val_cur_o,
  output logic [CW-1:0]    row_o,
  output logic [CW-1:0]    col_ab_o,
  output logic [CW-1:0]    col_o,
  output emit_t            emit_o
);

  localparam int                AW    = CW + 1;
  localparam logic [CW-1:0]     MAXM1 = CW'(MAX_SIDE - 1);

  logic [CW-1:0] nm1_q, r_q, c_q, r_d, c_d;
  logic          acc;

  // stage 1: memory read returns
  logic          s1_v_q, s1_med_q;
  logic [CW-1:0] s1_r_q, s1_c_q, s1_cab_q;
  logic [PB-1:0] s1_p_q, rd_old_q, rd_prev_q;
  emit_t         s1_e_q;
  // window
  logic [PB-1:0] win_q [3][3];
  logic [PB-1:0] win_d [3][3];
  // stage 2: neighbors captured
  logic          s2_v_q, s2_med_q;
  logic [CW-1:0] s2_r_q, s2_c_q, s2_cab_q;
  logic [PB-1:0] s2_p_q, s2_w11_q, s2_w12_q;
  logic [PB-1:0] nb_q [8];
  emit_t         s2_e_q;
  // stage 3: halves sorted
  logic          s3_v_q, s3_med_q;
  logic [CW-1:0] s3_r_q, s3_c_q, s3_cab_q;
  logic [PB-1:0] s3_p_q, s3_w11_q, s3_w12_q;
  logic [PB-1:0] hs_q [8];
  logic [PB-1:0] hs_d [8];
  emit_t         s3_e_q;

  logic [PB-1:0] t1 [8];
  logic [PB-1:0] t2 [8];
  logic [PB-1:0] m1 [8];
  logic [PB-1:0] m2 [8];
  logic [PB:0]   msum;
  logic [1:0]    inflight;
  logic [PB-1:0] mem [2**AW];

  assign inflight   = 2'(s1_v_q) + 2'(s2_v_q) + 2'(s3_v_q);
  assign in_stall_o = (32'(q_count_i) + 32'(inflight)) >= QDEPTH;
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    c_d = c_q;
    r_d = r_q;
    if (acc) begin
      if (c_q == nm1_q) begin
        c_d = '0;
        r_d = (r_q == nm1_q) ? '0 : r_q + 1'b1;
      end else begin
        c_d = c_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nm1_q  <= CW'(FRAME_RESET - 1'b1);
      r_q    <= '0;
      c_q    <= '0;
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      if (cfg_we_i) begin
        r_q <= '0;
        c_q <= '0;
        if (cfg_wdata_i == '0) begin
          nm1_q <= '0;
        end else if (32'(cfg_wdata_i) > MAX_SIDE) begin
          nm1_q <= MAXM1;
        end else begin
          nm1_q <= CW'(cfg_wdata_i - 1'b1);
        end
      end else begin
        r_q <= r_d;
        c_q <= c_d;
      end
      s1_v_q <= acc;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      if (s1_v_q) win_q <= win_d;
    end
  end

  // line stores: bank picked by row parity, read before write
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_old_q  <= mem[{r_q[0], c_q}];
      rd_prev_q <= mem[{~r_q[0], c_q}];
      mem[{r_q[0], c_q}] <= pixel_in_i;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = rd_old_q;
    win_d[1][2] = rd_prev_q;
    win_d[2][2] = s1_p_q;
  end

  // sort each half of four
  always_comb begin
    for (int h = 0; h < 8; h += 4) begin
      t1[h]   = (nb_q[h]   < nb_q[h+1]) ? nb_q[h]   : nb_q[h+1];
      t1[h+1] = (nb_q[h]   < nb_q[h+1]) ? nb_q[h+1] : nb_q[h];
      t1[h+2] = (nb_q[h+2] < nb_q[h+3]) ? nb_q[h+2] : nb_q[h+3];
      t1[h+3] = (nb_q[h+2] < nb_q[h+3]) ? nb_q[h+3] : nb_q[h+2];
      t2[h]   = (t1[h]   < t1[h+2]) ? t1[h]   : t1[h+2];
      t2[h+2] = (t1[h]   < t1[h+2]) ? t1[h+2] : t1[h];
      t2[h+1] = (t1[h+1] < t1[h+3]) ? t1[h+1] : t1[h+3];
      t2[h+3] = (t1[h+1] < t1[h+3]) ? t1[h+3] : t1[h+1];
      hs_d[h]   = t2[h];
      hs_d[h+3] = t2[h+3];
      hs_d[h+1] = (t2[h+1] < t2[h+2]) ? t2[h+1] : t2[h+2];
      hs_d[h+2] = (t2[h+1] < t2[h+2]) ? t2[h+2] : t2[h+1];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_r_q   <= r_q;
    s1_c_q   <= c_q;
    s1_cab_q <= (c_q == '0) ? '0 : c_q - 1'b1;
    s1_p_q   <= pixel_in_i;
    s1_med_q <= r_q > CW'(1);
    s1_e_q.ab   <= (r_q != '0) && (c_q == '0 || c_q > CW'(1));
    s1_e_q.rc   <= (r_q != '0) && (c_q == nm1_q) && (c_q != '0);
    s1_e_q.cur  <= r_q == nm1_q;
    s1_e_q.last <= c_q == nm1_q;

    s2_r_q   <= s1_r_q;
    s2_c_q   <= s1_c_q;
    s2_cab_q <= s1_cab_q;
    s2_p_q   <= s1_p_q;
    s2_med_q <= s1_med_q && (s1_c_q != '0);
    s2_e_q   <= s1_e_q;
    s2_w11_q <= win_d[1][1];
    s2_w12_q <= win_d[1][2];
    nb_q[0]  <= win_d[0][0];
    nb_q[1]  <= win_d[0][1];
    nb_q[2]  <= win_d[0][2];
    nb_q[3]  <= win_d[1][0];
    nb_q[4]  <= win_d[1][2];
    nb_q[5]  <= win_d[2][0];
    nb_q[6]  <= win_d[2][1];
    nb_q[7]  <= win_d[2][2];

    s3_r_q   <= s2_r_q;
    s3_c_q   <= s2_c_q;
    s3_cab_q <= s2_cab_q;
    s3_p_q   <= s2_p_q;
    s3_med_q <= s2_med_q;
    s3_e_q   <= s2_e_q;
    s3_w11_q <= s2_w11_q;
    s3_w12_q <= s2_w12_q;
    hs_q     <= hs_d;
  end

  // odd-even merge of the two sorted halves
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m1[i]   = (hs_q[i] < hs_q[i+4]) ? hs_q[i]   : hs_q[i+4];
      m1[i+4] = (hs_q[i] < hs_q[i+4]) ? hs_q[i+4] : hs_q[i];
    end
    m2 = m1;
    for (int i = 2; i < 4; i++) begin
      m2[i]   = (m1[i] < m1[i+2]) ? m1[i]   : m1[i+2];
      m2[i+2] = (m1[i] < m1[i+2]) ? m1[i+2] : m1[i];
    end
    // only the two middle ranks matter
    msum = ((m2[3] < m2[4]) ? {1'b0, m2[3]} : {1'b0, m2[4]})
         + ((m2[3] < m2[4]) ? {1'b0, m2[4]} : {1'b0, m2[3]});
  end

  assign push_o    = s3_v_q && (s3_e_q.ab || s3_e_q.rc || s3_e_q.cur);
  assign val_ab_o  = (s3_c_q == '0) ? s3_w12_q : (s3_med_q ? msum[PB:1] : s3_w11_q);
  assign val_rc_o  = s3_w12_q;
  assign val_cur_o = s3_p_q;
  assign row_o     = s3_r_q;
  assign col_ab_o  = s3_cab_q;
  assign col_o     = s3_c_q;
  assign emit_o    = s3_e_q;

endmodule

// File: design/nmf_queue.sv
// ----------------------------------------------------------------------------
// nmf_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module nmf_queue import nmf_pkg::*; #(
  parameter int W = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [W-1:0]   wdata_i,
  input  logic           pop_i,
  output logic [W-1:0]   rdata_o,
  output logic           valid_o,
  output logic [QAW:0]   count_o
);

  logic [W-1:0]   ent_q [QDEPTH];
  logic [QAW-1:0] wp_q, rp_q;
  logic [QAW:0]   cnt_q;
  logic           do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = cnt_q != '0;
  assign rdata_o = ent_q[rp_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (do_pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QAW+1)'(push_i) - (QAW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= wdata_i;
  end

endmodule

// File: design/nmf_back.sv
// ----------------------------------------------------------------------------
// nmf_back
// expands each job into its results and drives the output register
// ----------------------------------------------------------------------------
module nmf_back import nmf_pkg::*; #(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int CW = $clog2(MAX_SIDE),
  localparam int PB = PIXEL_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  input  logic [PB-1:0] val_ab_i,
  input  logic [PB-1:0] val_rc_i,
  input  logic [PB-1:0] val_cur_i,
  input  logic [CW-1:0] row_i,
  input  logic [CW-1:0] col_ab_i,
  input  logic [CW-1:0] col_i,
  input  emit_t         emit_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [PB-1:0] pixel_out_o,
  output logic [CW-1:0] out_row_o,
  output logic [CW-1:0] out_col_o,
  output logic          frame_last_o
);

  logic [PB-1:0] ab_q, rc_q, cur_q, pix_d;
  logic [CW-1:0] row_q, cab_q, col_q, orow_d, ocol_d;
  emit_t         m_q, m_d;
  logic          ov_q, out_free, busy, emit, last_d;

  assign out_free = !ov_q || !out_stall_i;
  assign busy     = m_q.ab || m_q.rc || m_q.cur;
  assign emit     = out_free && busy;

  always_comb begin
    m_d    = m_q;
    pix_d  = cur_q;
    orow_d = row_q;
    ocol_d = col_q;
    last_d = m_q.last;
    if (m_q.ab) begin
      pix_d  = ab_q;
      orow_d = row_q - 1'b1;
      ocol_d = cab_q;
      last_d = 1'b0;
      if (emit) m_d.ab = 1'b0;
    end else if (m_q.rc) begin
      pix_d  = rc_q;
      orow_d = row_q - 1'b1;
      last_d = 1'b0;
      if (emit) m_d.rc = 1'b0;
    end else if (emit) begin
      m_d.cur = 1'b0;
    end
    // refill as soon as the current job is spent
    q_pop_o = q_valid_i && !(m_d.ab || m_d.rc || m_d.cur);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      m_q <= q_pop_o ? emit_i : m_d;
      if (out_free) ov_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ab_q  <= val_ab_i;
      rc_q  <= val_rc_i;
      cur_q <= val_cur_i;
      row_q <= row_i;
      cab_q <= col_ab_i;
      col_q <= col_i;
    end
    if (emit) begin
      pixel_out_o  <= pix_d;
      out_row_o    <= orow_d;
      out_col_o    <= ocol_d;
      frame_last_o <= last_d;
    end
  end

  assign out_valid_o = ov_q;

endmodule

// File: design/neighbor_median_filter.sv
// ----------------------------------------------------------------------------
// neighbor_median_filter
// streaming 3x3 neighbor median filter over a square raster frame
// ----------------------------------------------------------------------------
// usage
//   input channel: one pixel word per accepted cycle (in_valid_i high,
//   in_stall_o low), raster order, frame side set by cfg_wdata_i
//   output channel: pixel, row, column and frame_last per word, taken
//   when out_valid_o is high and out_stall_i is low
//   interior pixels become the floor mean of the 4th and 5th smallest of
//   their eight neighbors, border pixels pass through; rows come out one
//   row late, the last row as it arrives, so a word causes up to three
//   result words
//   throughput: one input word per cycle while the back keeps up; the
//   single output register sets the limit of one result per cycle, so the
//   last row of a frame, whose words cause more results, takes input slower
//   path: a result passes the sort pipeline stages, the job queue and the
//   back's job registers before it reaches the output register
//   in_stall_o rises when the job queue plus the words in the sort
//   pipeline would fill it; a stalled receiver backs up the queue only
//   reset: position back to the frame start, frame side 3, no results
//   pending; the line stores hold garbage until written, which no result
//   reads; a frame size write also restarts the frame
// ----------------------------------------------------------------------------
module neighbor_median_filter import nmf_pkg::*; #(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int CW = $clog2(MAX_SIDE),
  localparam int PB = PIXEL_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [PB-1:0]    pixel_in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [PB-1:0]    pixel_out_o,
  output logic [CW-1:0]    out_row_o,
  output logic [CW-1:0]    out_col_o,
  output logic             frame_last_o
);

  // job word: three values, row, two columns, emit flags
  localparam int JW = 3*PB + 3*CW + EMIT_W;

  logic          push, pop, q_valid;
  logic [QAW:0]  q_count;
  logic [JW-1:0] job_in, job_out;
  logic [PB-1:0] f_ab, f_rc, f_cur, b_ab, b_rc, b_cur;
  logic [CW-1:0] f_row, f_cab, f_col, b_row, b_cab, b_col;
  emit_t         f_emit, b_emit;

  nmf_front #(.MAX_SIDE(MAX_SIDE), .PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .pixel_in_i,
    .q_count_i (q_count),
    .push_o    (push),
    .val_ab_o  (f_ab),
    .val_rc_o  (f_rc),
    .val_cur_o (f_cur),
    .row_o     (f_row),
    .col_ab_o  (f_cab),
    .col_o     (f_col),
    .emit_o    (f_emit)
  );

  assign job_in = {f_ab, f_rc, f_cur, f_row, f_cab, f_col, f_emit};

  nmf_queue #(.W(JW)) u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .wdata_i (job_in),
    .pop_i   (pop),
    .rdata_o (job_out),
    .valid_o (q_valid),
    .count_o (q_count)
  );

  assign {b_ab, b_rc, b_cur, b_row, b_cab, b_col, b_emit} = job_out;

  nmf_back #(.MAX_SIDE(MAX_SIDE), .PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_pop_o   (pop),
    .val_ab_i  (b_ab),
    .val_rc_i  (b_rc),
    .val_cur_i (b_cur),
    .row_i     (b_row),
    .col_ab_i  (b_cab),
    .col_i     (b_col),
    .emit_i    (b_emit),
    .out_valid_o, .out_stall_i, .pixel_out_o, .out_row_o, .out_col_o,
    .frame_last_o
  );

endmodule

// File: sim/nmf_checker.sv
// ----------------------------------------------------------------------------
// nmf_checker
// watches both channels of the neighbor median filter, predicts the result
// words of every accepted pixel word and compares them in order
// ----------------------------------------------------------------------------
module nmf_checker import nmf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_stall_o,
  input  logic [7:0]       pixel_in_i,
  input  logic             out_valid_o,
  input  logic             out_stall_i,
  input  logic [7:0]       pixel_out_o,
  input  logic [9:0]       out_row_o,
  input  logic [9:0]       out_col_o,
  input  logic             frame_last_o,
  output int               fail_cnt_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] pix;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
  } pix_word_t;

  pix_word_t  filtered_q[$];
  logic [CFG_W-1:0] side_reg;
  logic [7:0] lines[2][1024];
  logic [7:0] win[3][3];
  int unsigned row_pos, col_pos;

  assign pending_o = filtered_q.size();

  function automatic logic [7:0] nbr_median();
    logic [7:0] v[8];
    logic [7:0] t;
    int n;
    n = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        if (i != 1 || j != 1) begin
          v[n] = win[i][j];
          n++;
        end
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 7 - i; j++)
        if (v[j] > v[j+1]) begin
          t = v[j]; v[j] = v[j+1]; v[j+1] = t;
        end
    return 8'((9'(v[3]) + 9'(v[4])) >> 1);
  endfunction

  function automatic void push_word(logic [7:0] p, int unsigned r, int unsigned c, bit l);
    pix_word_t w;
    w.pix = p; w.row = 10'(r); w.col = 10'(c); w.last = l;
    filtered_q.push_back(w);
  endfunction

  task automatic filter_pixel(logic [7:0] p);
    int unsigned n, r, c;
    n = (side_reg == 0) ? 1 : (side_reg > 1024 ? 1024 : side_reg);
    r = row_pos;
    c = col_pos;
    if (r >= n || c >= n) begin
      r = 0; c = 0;
    end
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = lines[r & 1][c];
    win[1][2] = lines[(r + 1) & 1][c];
    win[2][2] = p;
    lines[r & 1][c] = p;
    if (r >= 1) begin
      if (c == 0) push_word(win[1][2], r - 1, 0, 0);
      // top row of the frame is border, interior rows get the median
      if (c >= 2) push_word((r >= 2) ? nbr_median() : win[1][1], r - 1, c - 1, 0);
      if (c == n - 1 && c != 0) push_word(win[1][2], r - 1, c, 0);
    end
    if (r == n - 1) push_word(p, r, c, c == n - 1);
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pix_word_t e;
    if (!rst_ni) begin
      side_reg   = FRAME_RESET;
      row_pos    = 0;
      col_pos    = 0;
      fail_cnt_o = 0;
      filtered_q.delete();
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] = '0;
    end else begin
      if (cfg_we_i) begin
        side_reg = cfg_wdata_i;
        row_pos  = 0;
        col_pos  = 0;
      end
      if (in_valid_i && !in_stall_o) filter_pixel(pixel_in_i);
      if (out_valid_o && !out_stall_i) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected result word row %0d col %0d", out_row_o, out_col_o);
          fail_cnt_o++;
        end else begin
          e = filtered_q.pop_front();
          if (pixel_out_o !== e.pix) begin
            $error("pixel_out exp %0d got %0d", e.pix, pixel_out_o); fail_cnt_o++;
          end
          if (out_row_o !== e.row) begin
            $error("out_row exp %0d got %0d", e.row, out_row_o); fail_cnt_o++;
          end
          if (out_col_o !== e.col) begin
            $error("out_col exp %0d got %0d", e.col, out_col_o); fail_cnt_o++;
          end
          if (frame_last_o !== e.last) begin
            $error("frame_last exp %0d got %0d", e.last, frame_last_o); fail_cnt_o++;
          end
        end
      end
    end
  end
endmodule

// File: sim/tb_neighbor_median_filter.sv
// ----------------------------------------------------------------------------
// tb_neighbor_median_filter
// stimulus and verdict for the neighbor median filter: whole frames of
// directed and random pixels over several frame sizes, random idling on
// both channels, checking done by nmf_checker
// ----------------------------------------------------------------------------
module tb_neighbor_median_filter import nmf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WD_LIMIT = 20000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic [7:0]       pixel_in_i = '0;
  logic             out_stall_i = 1'b0;
  logic             in_stall_o, out_valid_o, frame_last_o;
  logic [7:0]       pixel_out_o;
  logic [9:0]       out_row_o, out_col_o;
  int               fail_cnt, pending;
  int               sent_cnt = 0;
  bit               calm = 1'b0;   // no idling near the end
  int               idle_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  neighbor_median_filter dut (.*);

  nmf_checker checker_i (.*, .fail_cnt_o(fail_cnt), .pending_o(pending));

  // receiver stall bursts
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles with no word accepted
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // one pixel word, with a random sender gap before it
  task automatic send_pixel(logic [7:0] p);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_side(int unsigned s);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(s);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int unsigned side_now();
    return cfg_wdata_i;
  endfunction

  // full frame; mode 0 random, 1 extremes, 2 checker, 3 ramp
  task automatic send_frame(int unsigned n, int mode);
    logic [7:0] p;
    for (int unsigned r = 0; r < n; r++)
      for (int unsigned c = 0; c < n; c++) begin
        case (mode)
          1:       p = ($urandom_range(0, 1)) ? 8'hff : 8'h00;
          2:       p = ((r + c) & 1) ? 8'hff : 8'h00;
          3:       p = 8'(r * 16 + c * 7);
          default: p = 8'($urandom);
        endcase
        send_pixel(p);
      end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: reset side 3, tiny frames, clamps
    send_frame(3, 2);
    set_side(1);
    send_pixel(8'hff);
    send_pixel(8'h00);
    set_side(2);
    send_frame(2, 1);
    set_side(0);
    send_pixel(8'h5a);
    set_side(4);
    send_frame(4, 3);
    // restart mid frame
    send_pixel(8'h11);
    send_pixel(8'h22);
    set_side(2047);
    for (int i = 0; i < 3; i++) send_pixel(8'($urandom));
    set_side(1024);
    for (int i = 0; i < 30; i++) send_pixel(8'($urandom));
    // random frames of small sizes
    while (sent_cnt < 320) begin
      set_side($urandom_range(3, 9));
      send_frame(side_now(), 0);
    end
    calm = 1'b1;
    set_side(5);
    send_frame(5, 0);
    send_frame(5, 1);
    drain();
    if (fail_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
